[rtl/rrad_pkg.sv]
package rrad_pkg;

	localparam int MAX_ROUNDS_DEF = 10;

	typedef enum logic [2:0] {
		REG_KEY_LOW   = 3'd0,
		REG_KEY_HIGH  = 3'd1,
		REG_BASE_LOW  = 3'd2,
		REG_BASE_HIGH = 3'd3,
		REG_ROUNDS    = 3'd4,
		REG_OFFSET    = 3'd5,
		REG_FORWARD   = 3'd6
	} reg_idx_t;

	typedef logic [7:0] byte_t;

	// control carried along the round chain
	typedef struct packed {
		logic       vld;
		logic [3:0] last;
	} cell_ctl_t;

	function automatic byte_t sbox(input byte_t a);
		byte_t r;
		unique case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[rtl/rrad_key_cell.sv]
// One step of the key schedule: derives round key n+1 from round key n.
module rrad_key_cell
	import rrad_pkg::*;
(
	input  logic         clk,
	input  logic [127:0] key_in,
	input  logic [7:0]   rcon_in,
	output logic [127:0] key_out,
	output logic [7:0]   rcon_out
);
	logic [31:0]  t;
	logic [127:0] nk;

	always_comb begin
		t = {sbox(key_in[103:96]), sbox(key_in[127:120]), sbox(key_in[119:112]),
			sbox(key_in[111:104]) ^ rcon_in};
		nk[31:0]   = key_in[31:0] ^ t;
		nk[63:32]  = key_in[63:32] ^ nk[31:0];
		nk[95:64]  = key_in[95:64] ^ nk[63:32];
		nk[127:96] = key_in[127:96] ^ nk[95:64];
	end

	always_ff @(posedge clk) begin
		key_out  <= nk;
		rcon_out <= xtime(rcon_in);
	end
endmodule

[rtl/rrad_round_cell.sv]
// One AES round stage; passes the state through unchanged past the last round.
module rrad_round_cell
	import rrad_pkg::*;
#(
	parameter logic [3:0] ROUND = 4'd1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  cell_ctl_t    ctl_in,
	input  logic [127:0] st_in,
	input  logic [127:0] rkey,
	input  logic [7:0]   sel_in,
	output cell_ctl_t    ctl_out,
	output logic [127:0] st_out,
	output logic [7:0]   sel_out
);
	logic [127:0] sb, mc, nx;
	byte_t a0, a1, a2, a3, al;

	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				sb[8*(4*c+i) +: 8] = sbox(st_in[8*(4*((c+i)%4)+i) +: 8]);
		for (int c = 0; c < 4; c++) begin
			a0 = sb[32*c +: 8];
			a1 = sb[32*c+8 +: 8];
			a2 = sb[32*c+16 +: 8];
			a3 = sb[32*c+24 +: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
			mc[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
			mc[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mc[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		if (ROUND > ctl_in.last)
			nx = st_in;
		else if (ROUND == ctl_in.last)
			nx = sb ^ rkey;
		else
			nx = mc ^ rkey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_out <= '0;
		else if (en)
			ctl_out <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out  <= nx;
			sel_out <= sel_in;
		end
	end
endmodule

[rtl/reduced_round_aes_diagonal_probe_unit.sv]
// An input register feeds the round cells; output transactions leave the last cell.
// Throughput: one transaction per cycle; a full unrolled chain of round cells
// with one register each, stalled as a whole when the output is held.
// Key expansion runs through a MAX_ROUNDS-cell chain after a key write and
// settles within the idle time required before data.
// Reset clears valid flags and config (rounds to 10, key to zero); derived round key registers have no reset.
module reduced_round_aes_diagonal_probe_unit
	import rrad_pkg::*;
#(
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // diagonal_bytes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // projected_value
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data
);
	logic [63:0] key_low_q, key_high_q, base_low_q, base_high_q;
	logic [3:0]  rounds_q;
	logic [1:0]  offset_q;
	logic        forward_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0; key_high_q <= '0; base_low_q <= '0; base_high_q <= '0;
			rounds_q <= 4'd10; offset_q <= '0; forward_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_LOW:   key_low_q   <= cfg_data;
				REG_KEY_HIGH:  key_high_q  <= cfg_data;
				REG_BASE_LOW:  base_low_q  <= cfg_data;
				REG_BASE_HIGH: base_high_q <= cfg_data;
				REG_ROUNDS:    rounds_q    <= cfg_data[3:0];
				REG_OFFSET:    offset_q    <= cfg_data[1:0];
				REG_FORWARD:   forward_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule chain
	logic [127:0] rk [MAX_ROUNDS+1];
	logic [7:0]   rc [MAX_ROUNDS+1];
	assign rk[0] = {key_high_q, key_low_q};
	assign rc[0] = 8'h01;
	for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_key
		rrad_key_cell u_key (.clk, .key_in(rk[k]), .rcon_in(rc[k]),
			.key_out(rk[k+1]), .rcon_out(rc[k+1]));
	end

	// stall as a whole; output register is the last stage
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [3:0] last;
	always_comb begin
		if (rounds_q == 4'd0)
			last = 4'd1;
		else if (rounds_q > 4'(MAX_ROUNDS))
			last = 4'(MAX_ROUNDS);
		else
			last = rounds_q;
	end

	cell_ctl_t    ctl [MAX_ROUNDS+1];
	logic [127:0] st  [MAX_ROUNDS+1];
	logic [7:0]   sel [MAX_ROUNDS+1];
	logic [127:0] pt;

	always_comb begin
		pt = {base_high_q, base_low_q};
		pt[7:0]     = s_tdata[7:0];
		pt[47:40]   = s_tdata[15:8];
		pt[87:80]   = s_tdata[23:16];
		pt[127:120] = s_tdata[31:24];
	end

	// column of the diagonal per row, carried along
	logic [7:0] sel_in;
	always_comb begin
		for (int t = 0; t < 4; t++)
			sel_in[2*t +: 2] = forward_q ? offset_q + 2'(t) : offset_q - 2'(t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl[0] <= '0;
		else if (en)
			ctl[0] <= '{vld: s_tvalid, last: last};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0]  <= pt ^ rk[0];
			sel[0] <= sel_in;
		end
	end

	for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_rnd
		rrad_round_cell #(.ROUND(4'(r+1))) u_rnd (.clk, .arst_n, .en,
			.ctl_in(ctl[r]), .st_in(st[r]), .rkey(rk[r+1]), .sel_in(sel[r]),
			.ctl_out(ctl[r+1]), .st_out(st[r+1]), .sel_out(sel[r+1]));
	end

	logic [127:0] fin;
	assign fin = st[MAX_ROUNDS];
	always_comb begin
		for (int t = 0; t < 4; t++)
			m_tdata[8*t +: 8] = fin[8*(4*sel[MAX_ROUNDS][2*t +: 2] + t) +: 8];
	end
	assign m_tvalid = ctl[MAX_ROUNDS].vld;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && ctl[MAX_ROUNDS-1].vld |=> m_tvalid)
		else $error("item lost in last cell");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[0].vld |-> ctl[0].last >= 4'd1 && ctl[0].last <= 4'(MAX_ROUNDS))
		else $error("round count out of range in chain");
endmodule
